/* rtl/deo_pkg.sv */
`timescale 1ns / 1ps

package deo_pkg;

	localparam logic [1:0] REG_DIST_PER_TICK = 2'd0;
	localparam logic [1:0] REG_LEFT_HALF_W   = 2'd1;
	localparam logic [1:0] REG_RIGHT_HALF_W  = 2'd2;

	localparam logic [23:0] DPT_RESET = 24'd317219;
	localparam logic [15:0] LHW_RESET = 16'd1152;
	localparam logic [15:0] RHW_RESET = 16'd1152;

	localparam logic [29:0] ANG_SCALE   = 30'd683565276;
	localparam logic [4:0]  CORDIC_LAST = 5'd27;
	localparam logic [5:0]  DIV_STEPS   = 6'd58;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30_POS     = 34'sd1073741824;
	localparam logic signed [33:0] Q30_NEG     = -34'sd1073741824;
	localparam logic signed [58:0] Q28_POS     = 59'sd268435456;
	localparam logic signed [58:0] Q28_NEG     = -59'sd268435456;
	localparam logic signed [63:0] POS_MAX     = 64'sd140737488355327;
	localparam logic signed [63:0] POS_MIN     = -64'sd140737488355328;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_R,
		ST_DIV_Q,
		ST_CHK_Q,
		ST_MUL_P,
		ST_DIV_FR,
		ST_MUL_LF,
		ST_MUL_RF,
		ST_CHK_S,
		ST_COR_H,
		ST_DIV_S,
		ST_MUL_DH,
		ST_MUL_DL,
		ST_COR_P,
		ST_MUL_XH,
		ST_MUL_XL,
		ST_MUL_YH,
		ST_MUL_YL,
		ST_FIN
	} deo_state_t;

	function automatic logic [29:0] deo_atan(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [47:0] deo_sat48(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
		return c[47:0];
	endfunction

endpackage

/* rtl/differential_encoder_odometry.sv */
`timescale 1ns / 1ps

// Two-wheel arc odometry. Each item carries absolute left/right encoder counts; the
// result is the new pose (X, Y in signed Q32.16 inches, saturating; heading as a
// 32-bit binary angle that wraps). One item is processed at a time by a sequencer
// that drives a bit-serial shift-add multiplier (one multiplier bit per cycle), a
// 58-step restoring divider and a 28-step CORDIC. A straight move skips the turn
// arithmetic; a turning move runs the half-angle CORDIC and an extra divide only
// when the chord needs the sine of the half angle. The serial multiplier, the
// divider and the CORDIC iterations run one after the other, and the result waits
// on out_stall while the previous result is still held. The next item is taken in
// the cycle after the result moves to the output register, while that result waits there.
// Configuration writes are always accepted (cfg_ready is tied high).
module differential_encoder_odometry import deo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  left_count,
	input  logic signed [31:0]  right_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [47:0]  pos_x,
	output logic signed [47:0]  pos_y,
	output logic [31:0]         heading,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);

	deo_state_t st_q, st_d;
	logic go_q;

	logic [23:0] dpt_q;
	logic [15:0] lhw_q, rhw_q;
	logic [16:0] w;

	logic signed [31:0] prev_l_q, prev_r_q;
	logic signed [47:0] x_q, y_q;
	logic [31:0] hd_q;

	logic signed [32:0] dl_q, dr_q;
	logic signed [56:0] l24_q, r24_q;
	logic signed [57:0] q_q;
	logic [31:0] da_q, half_q;
	logic [14:0] fr_q, fl;
	logic signed [49:0] d_q;
	logic signed [29:0] s_q;
	logic signed [47:0] h_q;
	logic signed [31:0] sh_q, sp_q, cp_q;
	logic signed [63:0] t_q;

	logic signed [47:0] px_q, py_q;
	logic [31:0] ph_q;
	logic ov_q;

	// multiplier
	logic signed [63:0] ma_q, macc_q, m_add;
	logic [29:0] mb_q;
	logic [4:0] mcnt_q;
	logic msgn_q, m_busy;
	logic mul_go, mul_sgn;
	logic signed [63:0] mul_a;
	logic [29:0] mul_b;
	logic [4:0] mul_n;

	// divider
	logic [57:0] dn_q, drem_q, dd_q;
	logic [5:0] dcnt_q;
	logic dneg_q, d_busy;
	logic div_go;
	logic signed [58:0] div_num, div_den, num_mag, den_mag, div_res;
	logic [58:0] d_try;
	logic d_ge;

	// cordic
	logic signed [33:0] cx_q, cy_q, cz_q, c_sx, c_sy, c_at, c_xr, c_yr;
	logic [4:0] ci_q;
	logic c_busy_q, cflip_q;
	logic cor_go;
	logic [31:0] cor_ang, c_ang1, c_ang2;
	logic signed [31:0] sin_v, cos_v;

	logic busy_any, done, small_q;
	logic signed [58:0] s_clamp;

	assign w         = {1'b0, lhw_q} + {1'b0, rhw_q};
	assign fl        = 15'd16384 - fr_q;
	assign in_stall  = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;
	assign pos_x     = px_q;
	assign pos_y     = py_q;
	assign heading   = ph_q;
	assign m_busy    = (mcnt_q != 5'd0);
	assign d_busy    = (dcnt_q != 6'd0);
	assign busy_any  = m_busy | d_busy | c_busy_q;
	assign done      = go_q & ~busy_any;
	assign small_q   = (q_q > -58'sd256) && (q_q < 58'sd256);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (in_valid) st_d = ST_MUL_L;
			ST_MUL_L:  if (done) st_d = ST_MUL_R;
			ST_MUL_R:  if (done) st_d = ST_DIV_Q;
			ST_DIV_Q:  if (done) st_d = ST_CHK_Q;
			ST_CHK_Q:  st_d = (q_q == '0) ? ST_COR_P : ST_MUL_P;
			ST_MUL_P:  if (done) st_d = ST_DIV_FR;
			ST_DIV_FR: if (done) st_d = ST_MUL_LF;
			ST_MUL_LF: if (done) st_d = ST_MUL_RF;
			ST_MUL_RF: if (done) st_d = ST_CHK_S;
			ST_CHK_S:  st_d = small_q ? ST_MUL_DH : ST_COR_H;
			ST_COR_H:  if (done) st_d = ST_DIV_S;
			ST_DIV_S:  if (done) st_d = ST_MUL_DH;
			ST_MUL_DH: if (done) st_d = ST_MUL_DL;
			ST_MUL_DL: if (done) st_d = ST_COR_P;
			ST_COR_P:  if (done) st_d = ST_MUL_XH;
			ST_MUL_XH: if (done) st_d = ST_MUL_XL;
			ST_MUL_XL: if (done) st_d = ST_MUL_YH;
			ST_MUL_YH: if (done) st_d = ST_MUL_YL;
			ST_MUL_YL: if (done) st_d = ST_FIN;
			ST_FIN:    if (!ov_q || !out_stall) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// unit starts and operand selection
	always_comb begin
		mul_go  = 1'b0;
		div_go  = 1'b0;
		cor_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_n   = '0;
		mul_sgn = 1'b0;
		div_num = '0;
		div_den = '0;
		cor_ang = '0;
		unique case (st_q)
			ST_MUL_L: begin
				mul_go = !go_q; mul_a = 64'(dl_q); mul_b = 30'(dpt_q); mul_n = 5'd24;
			end
			ST_MUL_R: begin
				mul_go = !go_q; mul_a = 64'(dr_q); mul_b = 30'(dpt_q); mul_n = 5'd24;
			end
			ST_DIV_Q: begin
				div_go  = !go_q;
				div_num = 59'(l24_q) - 59'(r24_q);
				div_den = 59'(w);
			end
			ST_MUL_P: begin
				mul_go = !go_q; mul_a = 64'(q_q); mul_b = ANG_SCALE; mul_n = 5'd30;
			end
			ST_DIV_FR: begin
				div_go  = !go_q;
				div_num = 59'({rhw_q, 14'd0}) + 59'(w >> 1);
				div_den = 59'(w);
			end
			ST_MUL_LF: begin
				mul_go = !go_q; mul_a = 64'(l24_q >>> 8); mul_b = 30'(fr_q); mul_n = 5'd15;
			end
			ST_MUL_RF: begin
				mul_go = !go_q; mul_a = 64'(r24_q >>> 8); mul_b = 30'(fl); mul_n = 5'd15;
			end
			ST_COR_H: begin
				cor_go = !go_q; cor_ang = half_q;
			end
			ST_DIV_S: begin
				div_go  = !go_q;
				div_num = 59'(sh_q) <<< 15;
				div_den = 59'(q_q);
			end
			ST_MUL_DH: begin
				mul_go = !go_q; mul_a = 64'(d_q); mul_b = 30'(s_q >>> 15);
				mul_n = 5'd17; mul_sgn = 1'b1;
			end
			ST_MUL_DL: begin
				mul_go = !go_q; mul_a = 64'(d_q); mul_b = 30'(s_q[14:0]); mul_n = 5'd15;
			end
			ST_COR_P: begin
				cor_go = !go_q; cor_ang = hd_q + half_q;
			end
			ST_MUL_XH: begin
				mul_go = !go_q; mul_a = 64'(h_q); mul_b = 30'(sp_q >>> 15);
				mul_n = 5'd17; mul_sgn = 1'b1;
			end
			ST_MUL_XL: begin
				mul_go = !go_q; mul_a = 64'(h_q); mul_b = 30'(sp_q[14:0]); mul_n = 5'd15;
			end
			ST_MUL_YH: begin
				mul_go = !go_q; mul_a = 64'(h_q); mul_b = 30'(cp_q >>> 15);
				mul_n = 5'd17; mul_sgn = 1'b1;
			end
			ST_MUL_YL: begin
				mul_go = !go_q; mul_a = 64'(h_q); mul_b = 30'(cp_q[14:0]); mul_n = 5'd15;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (mul_go || div_go || cor_go) begin
				go_q <= 1'b1;
			end else if (done) begin
				go_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DPT_RESET;
			lhw_q <= LHW_RESET;
			rhw_q <= RHW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIST_PER_TICK: dpt_q <= cfg_data;
				REG_LEFT_HALF_W:   lhw_q <= cfg_data[15:0];
				REG_RIGHT_HALF_W:  rhw_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// serial multiplier: one multiplier bit per cycle, top bit negative when signed
	always_comb begin
		m_add = '0;
		if (mb_q[0]) begin
			m_add = (mcnt_q == 5'd1 && msgn_q) ? -ma_q : ma_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (mul_go) begin
			mcnt_q <= mul_n;
		end else if (m_busy) begin
			mcnt_q <= mcnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q   <= mul_a;
			mb_q   <= mul_b;
			msgn_q <= mul_sgn;
			macc_q <= '0;
		end else if (m_busy) begin
			ma_q   <= ma_q <<< 1;
			mb_q   <= mb_q >> 1;
			macc_q <= macc_q + m_add;
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign num_mag = div_num[58] ? -div_num : div_num;
	assign den_mag = div_den[58] ? -div_den : div_den;
	assign d_try   = {drem_q, dn_q[57]};
	assign d_ge    = (d_try >= {1'b0, dd_q});
	assign div_res = dneg_q ? -$signed({1'b0, dn_q}) : $signed({1'b0, dn_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_go) begin
			dcnt_q <= DIV_STEPS;
		end else if (d_busy) begin
			dcnt_q <= dcnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			dn_q   <= num_mag[57:0];
			dd_q   <= den_mag[57:0];
			drem_q <= '0;
			dneg_q <= div_num[58] ^ div_den[58];
		end else if (d_busy) begin
			drem_q <= d_ge ? 58'(d_try - {1'b0, dd_q}) : d_try[57:0];
			dn_q   <= {dn_q[56:0], d_ge};
		end
	end

	// CORDIC rotation, one step per cycle
	assign c_ang1 = cor_ang + 32'h4000_0000;
	assign c_ang2 = cor_ang ^ {c_ang1[31], 31'd0};
	assign c_sx   = cy_q >>> ci_q;
	assign c_sy   = cx_q >>> ci_q;
	assign c_at   = $signed({4'd0, deo_atan(ci_q)});
	assign c_xr   = cflip_q ? -cx_q : cx_q;
	assign c_yr   = cflip_q ? -cy_q : cy_q;
	assign sin_v  = (c_yr > Q30_POS) ? 32'(Q30_POS) : ((c_yr < Q30_NEG) ? 32'(Q30_NEG) : 32'(c_yr));
	assign cos_v  = (c_xr > Q30_POS) ? 32'(Q30_POS) : ((c_xr < Q30_NEG) ? 32'(Q30_NEG) : 32'(c_xr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_busy_q <= 1'b0;
			ci_q     <= '0;
		end else if (cor_go) begin
			c_busy_q <= 1'b1;
			ci_q     <= '0;
		end else if (c_busy_q) begin
			ci_q <= ci_q + 5'd1;
			if (ci_q == CORDIC_LAST) begin
				c_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cor_go) begin
			cx_q    <= CORDIC_GAIN;
			cy_q    <= '0;
			cz_q    <= 34'($signed(c_ang2));
			cflip_q <= c_ang1[31];
		end else if (c_busy_q) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - c_sx;
				cy_q <= cy_q + c_sy;
				cz_q <= cz_q - c_at;
			end else begin
				cx_q <= cx_q + c_sx;
				cy_q <= cy_q - c_sy;
				cz_q <= cz_q + c_at;
			end
		end
	end

	assign s_clamp = (div_res > Q28_POS) ? Q28_POS : ((div_res < Q28_NEG) ? Q28_NEG : div_res);

	// odometry state and intermediate results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
			hd_q     <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (st_q == ST_FIN && (!ov_q || !out_stall)) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					prev_l_q <= left_count;
					prev_r_q <= right_count;
				end
				ST_MUL_XL: if (done) begin
					x_q <= deo_sat48(64'(x_q) + t_q + (macc_q >>> 30));
				end
				ST_MUL_YL: if (done) begin
					y_q <= deo_sat48(64'(y_q) + t_q + (macc_q >>> 30));
				end
				ST_FIN: if (!ov_q || !out_stall) begin
					hd_q <= hd_q + da_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (in_valid) begin
				dl_q <= 33'(left_count) - 33'(prev_l_q);
				dr_q <= 33'(right_count) - 33'(prev_r_q);
			end
			ST_MUL_L: if (done) l24_q <= macc_q[56:0];
			ST_MUL_R: if (done) r24_q <= macc_q[56:0];
			ST_DIV_Q: if (done) q_q <= (w == '0) ? '0 : div_res[57:0];
			ST_CHK_Q: if (q_q == '0) begin
				h_q    <= deo_sat48(64'(r24_q >>> 8));
				half_q <= '0;
				da_q   <= '0;
			end
			ST_MUL_P: if (done) begin
				da_q   <= macc_q[47:16];
				half_q <= macc_q[48:17];
			end
			ST_DIV_FR: if (done) fr_q <= div_res[14:0];
			ST_MUL_LF: if (done) t_q <= macc_q;
			ST_MUL_RF: if (done) d_q <= 50'((t_q + macc_q) >>> 14);
			ST_CHK_S: if (small_q) s_q <= 30'(Q28_POS);
			ST_COR_H: if (done) sh_q <= sin_v;
			ST_DIV_S: if (done) s_q <= s_clamp[29:0];
			ST_MUL_DH: if (done) t_q <= macc_q >>> 13;
			ST_MUL_DL: if (done) h_q <= deo_sat48(t_q + (macc_q >>> 28));
			ST_COR_P: if (done) begin
				sp_q <= sin_v;
				cp_q <= cos_v;
			end
			ST_MUL_XH: if (done) t_q <= macc_q >>> 15;
			ST_MUL_YH: if (done) t_q <= macc_q >>> 15;
			ST_FIN: if (!ov_q || !out_stall) begin
				px_q <= x_q;
				py_q <= y_q;
				ph_q <= hd_q + da_q;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({m_busy, d_busy, c_busy_q}))
		else $error("more than one arithmetic unit busy");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == ST_MUL_L)
		else $error("accepted item did not start the sequence");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == ST_FIN)
		else $error("result raised outside the final state");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_go || div_go || cor_go) |-> !busy_any)
		else $error("unit started while another is busy");
`endif

endmodule
